// ===== src/hsv_to_rgb_converter_defines.svh =====
// Assertion macros for the colour converter. They sample on clk and stand
// down while rst_n is low.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTH
`define HSVRGB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");
`define HSVRGB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");
`else
`define HSVRGB_ASSERT_NOW(label, ante, cons)
`define HSVRGB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/hsvrgb_pkg.sv =====
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned HUE_W  = 16;
  localparam int unsigned UNIT_W = 14;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned SEC_W  = 4;
  localparam int unsigned GAP_W  = 13;  // offset within a sector, 0..6000
  localparam int unsigned LVL_W  = 27;  // levels in units of 1e-8, up to 1e8
  localparam int unsigned PROD_W = 40;  // chroma times sector offset
  localparam int unsigned NUM_W  = 36;  // that product shifted down by 4
  localparam int unsigned PP_W   = 46;  // partial products of the reciprocal

  localparam int unsigned UNIT_ONE    = 10000;
  localparam int unsigned SECTOR_SPAN = 6000;
  localparam int unsigned MAX_SECTOR  = (2**HUE_W - 1) / SECTOR_SPAN;
  localparam int unsigned HALF_SCALE  = 50000000;

  // Sector codes; anything above the last one places like magenta-red.
  localparam logic [SEC_W-1:0] SEC_RED_YEL = 4'd0;
  localparam logic [SEC_W-1:0] SEC_YEL_GRN = 4'd1;
  localparam logic [SEC_W-1:0] SEC_GRN_CYN = 4'd2;
  localparam logic [SEC_W-1:0] SEC_CYN_BLU = 4'd3;
  localparam logic [SEC_W-1:0] SEC_BLU_MAG = 4'd4;

  // Divide by 6000 = 16 * 375: shift, then reciprocal multiply and one fix-up.
  localparam int unsigned X_SHIFT       = 4;
  localparam int unsigned X_DIV         = 375;
  localparam int unsigned X_RECIP_SHIFT = 36;
  localparam int unsigned X_RECIP_W     = 28;
  localparam logic [X_RECIP_W-1:0] X_RECIP =
    X_RECIP_W'((64'd1 << X_RECIP_SHIFT) / 64'd375);
  localparam int unsigned X_SPLIT = NUM_W / 2;

  // Divide by 1e8 = 256 * 390625, same scheme on the channel level.
  localparam int unsigned C_SHIFT       = 8;
  localparam int unsigned C_DIV         = 390625;
  localparam int unsigned C_RECIP_SHIFT = 27;
  localparam int unsigned C_RECIP_W     = 9;
  localparam logic [C_RECIP_W-1:0] C_RECIP =
    C_RECIP_W'((64'd1 << C_RECIP_SHIFT) / 64'd390625);
  localparam int unsigned SCALED_W = 35;

  localparam int unsigned NUM_STAGES = 12;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [UNIT_W-1:0] saturation;
    logic [UNIT_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// ===== src/hsv_to_rgb_converter.sv =====
// Channel  Dir  Handshake            Payload
// in_      in   in_valid / in_stall   hsvrgb_pkg::hsv_t (hue, saturation, brightness)
// out_     out  out_valid / out_stall hsvrgb_pkg::rgb_t (red, green, blue)
//
// Twelve register stages; one request is taken every cycle while the output
// is not stalled.
// The depth is set by the two reciprocal divisions (by 6000 and by 1e8),
// each spread over a multiply, a back-multiply and a fix-up (the one by 6000 with a wide add).
// Each stage holds while the one after it is full and held, so empty stages
// still fill behind a stalled result.
// rst_n clears the valid bits only; data registers are not reset.
`default_nettype none
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire hsvrgb_pkg::hsv_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output hsvrgb_pkg::rgb_t      out_data
);

  localparam int unsigned NS     = hsvrgb_pkg::NUM_STAGES;
  localparam int unsigned HUE_W  = hsvrgb_pkg::HUE_W;
  localparam int unsigned UNIT_W = hsvrgb_pkg::UNIT_W;
  localparam int unsigned CH_W   = hsvrgb_pkg::CH_W;
  localparam int unsigned SEC_W  = hsvrgb_pkg::SEC_W;
  localparam int unsigned GAP_W  = hsvrgb_pkg::GAP_W;
  localparam int unsigned LVL_W  = hsvrgb_pkg::LVL_W;
  localparam int unsigned PROD_W = hsvrgb_pkg::PROD_W;
  localparam int unsigned NUM_W  = hsvrgb_pkg::NUM_W;
  localparam int unsigned PP_W   = hsvrgb_pkg::PP_W;
  localparam int unsigned SPLIT  = hsvrgb_pkg::X_SPLIT;
  localparam int unsigned SC_W   = hsvrgb_pkg::SCALED_W;
  localparam int unsigned RS     = hsvrgb_pkg::X_RECIP_SHIFT;
  localparam int unsigned CRS    = hsvrgb_pkg::C_RECIP_SHIFT;
  localparam int unsigned C2_W   = LVL_W + hsvrgb_pkg::C_RECIP_W;

  localparam logic [UNIT_W-1:0] UNIT_MAX = UNIT_W'(hsvrgb_pkg::UNIT_ONE);
  localparam logic [GAP_W-1:0]  SPAN     = GAP_W'(hsvrgb_pkg::SECTOR_SPAN);

  // stage control
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign vld_nxt   = (vld_r & ~en) | ({vld_r[NS-2:0], in_valid} & en);
  assign in_stall  = !en[0];
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: clamp, find sector
  logic [UNIT_W-1:0] s1_sat_nxt, s1_val_nxt, s1_sat_r, s1_val_r;
  logic [SEC_W-1:0]  s1_sec_nxt, s1_sec_r;
  logic [HUE_W-1:0]  s1_hue_r;

  always_comb begin
    s1_sat_nxt = (in_data.saturation > UNIT_MAX) ? UNIT_MAX : in_data.saturation;
    s1_val_nxt = (in_data.brightness > UNIT_MAX) ? UNIT_MAX : in_data.brightness;
    s1_sec_nxt = '0;
    for (int k = 1; k <= int'(hsvrgb_pkg::MAX_SECTOR); k++) begin
      if (in_data.hue >= HUE_W'(k * hsvrgb_pkg::SECTOR_SPAN)) begin
        s1_sec_nxt = SEC_W'(k);
      end
    end
  end

  // stage 2: chroma, v scaled, offset within the sector
  logic [LVL_W-1:0] s2_c_nxt, s2_vs_nxt, s2_c_r, s2_vs_r;
  logic [HUE_W-1:0] s2_base;
  logic [GAP_W-1:0] s2_f, s2_g_nxt, s2_g_r;
  logic [SEC_W-1:0] s2_sec_r;

  always_comb begin
    s2_c_nxt  = LVL_W'(28'(s1_val_r) * 28'(s1_sat_r));
    s2_vs_nxt = LVL_W'(28'(s1_val_r) * 28'(hsvrgb_pkg::UNIT_ONE));
    s2_base   = HUE_W'(HUE_W'(s1_sec_r) * HUE_W'(hsvrgb_pkg::SECTOR_SPAN));
    s2_f      = GAP_W'(s1_hue_r - s2_base);
    s2_g_nxt  = s1_sec_r[0] ? (SPAN - s2_f) : s2_f;
  end

  // stage 3: chroma times offset, m
  logic [PROD_W-1:0] s3_p_nxt, s3_p_r;
  logic [LVL_W-1:0]  s3_m_nxt, s3_m_r, s3_c_r;
  logic [SEC_W-1:0]  s3_sec_r;

  assign s3_p_nxt = PROD_W'(s2_c_r) * PROD_W'(s2_g_r);
  assign s3_m_nxt = s2_vs_r - s2_c_r;

  // stage 4: reciprocal partial products
  logic [NUM_W-1:0] s4_n_nxt, s4_n_r;
  logic [PP_W-1:0]  s4_pph_nxt, s4_ppl_nxt, s4_pph_r, s4_ppl_r;
  logic [LVL_W-1:0] s4_m_r, s4_c_r;
  logic [SEC_W-1:0] s4_sec_r;

  assign s4_n_nxt   = s3_p_r[PROD_W-1:hsvrgb_pkg::X_SHIFT];
  assign s4_pph_nxt = PP_W'(s4_n_nxt[NUM_W-1:SPLIT]) * PP_W'(hsvrgb_pkg::X_RECIP);
  assign s4_ppl_nxt = PP_W'(s4_n_nxt[SPLIT-1:0]) * PP_W'(hsvrgb_pkg::X_RECIP);

  // stage 5: sum partial products, estimate quotient
  logic [63:0]      s5_sum;
  logic [LVL_W-1:0] s5_q_nxt, s5_q_r, s5_m_r, s5_c_r;
  logic [NUM_W-1:0] s5_n_r;
  logic [SEC_W-1:0] s5_sec_r;

  assign s5_sum   = (64'(s4_pph_r) << SPLIT) + 64'(s4_ppl_r);
  assign s5_q_nxt = s5_sum[RS+LVL_W-1:RS];

  // stage 6: back-multiply the estimate
  logic [NUM_W-1:0] s6_qd_nxt, s6_qd_r, s6_n_r;
  logic [LVL_W-1:0] s6_q_r, s6_m_r, s6_c_r;
  logic [SEC_W-1:0] s6_sec_r;

  assign s6_qd_nxt = NUM_W'(s5_q_r) * NUM_W'(hsvrgb_pkg::X_DIV);

  // stage 7: fix up the estimate by one
  logic [NUM_W-1:0] s7_rem;
  logic [LVL_W-1:0] s7_x_nxt, s7_x_r, s7_m_r, s7_c_r;
  logic [SEC_W-1:0] s7_sec_r;

  assign s7_rem   = s6_n_r - s6_qd_r;
  assign s7_x_nxt = s6_q_r + LVL_W'(s7_rem >= NUM_W'(hsvrgb_pkg::X_DIV));

  // stage 8: place components per sector, add m
  logic [LVL_W-1:0] s8_cmp[3];
  logic [LVL_W-1:0] s8_lvl_nxt[3];
  logic [LVL_W-1:0] s8_lvl_r[3];

  always_comb begin
    case (s7_sec_r)
      hsvrgb_pkg::SEC_RED_YEL: begin
        s8_cmp[0] = s7_c_r; s8_cmp[1] = s7_x_r; s8_cmp[2] = '0;
      end
      hsvrgb_pkg::SEC_YEL_GRN: begin
        s8_cmp[0] = s7_x_r; s8_cmp[1] = s7_c_r; s8_cmp[2] = '0;
      end
      hsvrgb_pkg::SEC_GRN_CYN: begin
        s8_cmp[0] = '0; s8_cmp[1] = s7_c_r; s8_cmp[2] = s7_x_r;
      end
      hsvrgb_pkg::SEC_CYN_BLU: begin
        s8_cmp[0] = '0; s8_cmp[1] = s7_x_r; s8_cmp[2] = s7_c_r;
      end
      hsvrgb_pkg::SEC_BLU_MAG: begin
        s8_cmp[0] = s7_x_r; s8_cmp[1] = '0; s8_cmp[2] = s7_c_r;
      end
      default: begin
        s8_cmp[0] = s7_c_r; s8_cmp[1] = '0; s8_cmp[2] = s7_x_r;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      s8_lvl_nxt[i] = s8_cmp[i] + s7_m_r;
    end
  end

  // stages 9 to 12: scale to 255 and round, per channel
  logic [SC_W-1:0]  s9_scaled[3];
  logic [LVL_W-1:0] s9_n2_nxt[3];
  logic [LVL_W-1:0] s9_n2_r[3];
  logic [C2_W-1:0]  s10_prod[3];
  logic [CH_W-1:0]  s10_q_nxt[3];
  logic [CH_W-1:0]  s10_q_r[3];
  logic [LVL_W-1:0] s10_n2_r[3];
  logic [LVL_W-1:0] s11_qd_nxt[3];
  logic [LVL_W-1:0] s11_qd_r[3];
  logic [CH_W-1:0]  s11_q_r[3];
  logic [LVL_W-1:0] s11_n2_r[3];
  logic [LVL_W-1:0] s12_rem[3];
  logic [CH_W-1:0]  s12_ch[3];
  hsvrgb_pkg::rgb_t out_data_nxt, out_data_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s9_scaled[i]  = (SC_W'(s8_lvl_r[i]) << CH_W) - SC_W'(s8_lvl_r[i])
                      + SC_W'(hsvrgb_pkg::HALF_SCALE);
      s9_n2_nxt[i]  = s9_scaled[i][SC_W-1:hsvrgb_pkg::C_SHIFT];
      s10_prod[i]   = C2_W'(s9_n2_r[i]) * C2_W'(hsvrgb_pkg::C_RECIP);
      s10_q_nxt[i]  = s10_prod[i][CRS+CH_W-1:CRS];
      s11_qd_nxt[i] = LVL_W'(LVL_W'(s10_q_r[i]) * LVL_W'(hsvrgb_pkg::C_DIV));
      s12_rem[i]    = s11_n2_r[i] - s11_qd_r[i];
      s12_ch[i]     = s11_q_r[i] + CH_W'(s12_rem[i] >= LVL_W'(hsvrgb_pkg::C_DIV));
    end
    out_data_nxt.red   = s12_ch[0];
    out_data_nxt.green = s12_ch[1];
    out_data_nxt.blue  = s12_ch[2];
  end

  assign out_data = out_data_r;

  // data registers, each stage loads when it advances
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_hue_r <= in_data.hue;
      s1_sat_r <= s1_sat_nxt;
      s1_val_r <= s1_val_nxt;
      s1_sec_r <= s1_sec_nxt;
    end
    if (en[1]) begin
      s2_c_r   <= s2_c_nxt;
      s2_vs_r  <= s2_vs_nxt;
      s2_g_r   <= s2_g_nxt;
      s2_sec_r <= s1_sec_r;
    end
    if (en[2]) begin
      s3_p_r   <= s3_p_nxt;
      s3_m_r   <= s3_m_nxt;
      s3_c_r   <= s2_c_r;
      s3_sec_r <= s2_sec_r;
    end
    if (en[3]) begin
      s4_n_r   <= s4_n_nxt;
      s4_pph_r <= s4_pph_nxt;
      s4_ppl_r <= s4_ppl_nxt;
      s4_m_r   <= s3_m_r;
      s4_c_r   <= s3_c_r;
      s4_sec_r <= s3_sec_r;
    end
    if (en[4]) begin
      s5_q_r   <= s5_q_nxt;
      s5_n_r   <= s4_n_r;
      s5_m_r   <= s4_m_r;
      s5_c_r   <= s4_c_r;
      s5_sec_r <= s4_sec_r;
    end
    if (en[5]) begin
      s6_qd_r  <= s6_qd_nxt;
      s6_q_r   <= s5_q_r;
      s6_n_r   <= s5_n_r;
      s6_m_r   <= s5_m_r;
      s6_c_r   <= s5_c_r;
      s6_sec_r <= s5_sec_r;
    end
    if (en[6]) begin
      s7_x_r   <= s7_x_nxt;
      s7_m_r   <= s6_m_r;
      s7_c_r   <= s6_c_r;
      s7_sec_r <= s6_sec_r;
    end
    for (int i = 0; i < 3; i++) begin
      if (en[7]) begin
        s8_lvl_r[i] <= s8_lvl_nxt[i];
      end
      if (en[8]) begin
        s9_n2_r[i] <= s9_n2_nxt[i];
      end
      if (en[9]) begin
        s10_q_r[i]  <= s10_q_nxt[i];
        s10_n2_r[i] <= s9_n2_r[i];
      end
      if (en[10]) begin
        s11_qd_r[i] <= s11_qd_nxt[i];
        s11_q_r[i]  <= s10_q_r[i];
        s11_n2_r[i] <= s10_n2_r[i];
      end
    end
    if (en[11]) begin
      out_data_r <= out_data_nxt;
    end
  end

  `HSVRGB_ASSERT_NEXT(a_take_fills_first, in_valid && !in_stall, vld_r[0])
  `HSVRGB_ASSERT_NOW(a_x_fixup_range, vld_r[5], s7_rem < NUM_W'(2 * hsvrgb_pkg::X_DIV))
  `HSVRGB_ASSERT_NOW(a_x_within_chroma, vld_r[6], s7_x_r <= s7_c_r)
  `HSVRGB_ASSERT_NOW(a_ch_fixup_range, vld_r[10],
                     s12_rem[0] < LVL_W'(2 * hsvrgb_pkg::C_DIV) &&
                     s12_rem[1] < LVL_W'(2 * hsvrgb_pkg::C_DIV) &&
                     s12_rem[2] < LVL_W'(2 * hsvrgb_pkg::C_DIV))

endmodule

`default_nettype wire

// ===== sim/hsv_to_rgb_converter_test.sv =====
`timescale 1ns / 100ps

module hsv_to_rgb_converter_test;

  localparam longint unsigned FULL_SCALE  = 100000000;
  localparam int              RESET_TICKS = 12;
  localparam int              PIPE_DEPTH  = hsvrgb_pkg::NUM_STAGES;
  localparam int              CYCLE_LIMIT = 200000;
  localparam int              RANDOM_REQS = 1600;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_ALTERNATE
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hsvrgb_pkg::hsv_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hsvrgb_pkg::rgb_t out_data;

  hsvrgb_pkg::hsv_t hsv_backlog[$];
  hsvrgb_pkg::rgb_t rgb_awaited[$];
  int   mismatches = 0;
  int   cycle_count = 0;

  // sender burst shaping
  int burst_left = 0;
  int gap_left = 0;

  // receiver stall shaping
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;
  logic        alt_phase = 1'b0;

  hsv_to_rgb_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [hsvrgb_pkg::CH_W-1:0] level_to_channel(longint unsigned level);
    longint unsigned scaled;
    scaled = (level * 255 + hsvrgb_pkg::HALF_SCALE) / FULL_SCALE;
    return scaled[hsvrgb_pkg::CH_W-1:0];
  endfunction

  function automatic hsvrgb_pkg::rgb_t hsv_to_rgb(hsvrgb_pkg::hsv_t colour);
    longint unsigned sat, val, chroma, offs, second, base, rp, gp, bp;
    longint unsigned sector;
    hsvrgb_pkg::rgb_t result;
    sat = (colour.saturation > hsvrgb_pkg::UNIT_ONE) ? hsvrgb_pkg::UNIT_ONE
                                                     : colour.saturation;
    val = (colour.brightness > hsvrgb_pkg::UNIT_ONE) ? hsvrgb_pkg::UNIT_ONE
                                                     : colour.brightness;
    chroma = val * sat;
    sector = colour.hue / hsvrgb_pkg::SECTOR_SPAN;
    offs = colour.hue % hsvrgb_pkg::SECTOR_SPAN;
    base = val * hsvrgb_pkg::UNIT_ONE - chroma;
    // odd sectors fall, even sectors rise, also past the nominal hue range
    if (sector[0])
      second = chroma * (hsvrgb_pkg::SECTOR_SPAN - offs) / hsvrgb_pkg::SECTOR_SPAN;
    else
      second = chroma * offs / hsvrgb_pkg::SECTOR_SPAN;
    case (sector[hsvrgb_pkg::SEC_W-1:0])
      hsvrgb_pkg::SEC_RED_YEL: begin rp = chroma; gp = second; bp = 0;      end
      hsvrgb_pkg::SEC_YEL_GRN: begin rp = second; gp = chroma; bp = 0;      end
      hsvrgb_pkg::SEC_GRN_CYN: begin rp = 0;      gp = chroma; bp = second; end
      hsvrgb_pkg::SEC_CYN_BLU: begin rp = 0;      gp = second; bp = chroma; end
      hsvrgb_pkg::SEC_BLU_MAG: begin rp = second; gp = 0;      bp = chroma; end
      default:                 begin rp = chroma; gp = 0;      bp = second; end
    endcase
    result.red   = level_to_channel(rp + base);
    result.green = level_to_channel(gp + base);
    result.blue  = level_to_channel(bp + base);
    return result;
  endfunction

  task automatic queue_colour(int h, int s, int v);
    hsvrgb_pkg::hsv_t colour;
    colour.hue        = h[hsvrgb_pkg::HUE_W-1:0];
    colour.saturation = s[hsvrgb_pkg::UNIT_W-1:0];
    colour.brightness = v[hsvrgb_pkg::UNIT_W-1:0];
    hsv_backlog.push_back(colour);
  endtask

  // Sender: take note of the accepted request, then present the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        rgb_awaited.push_back(hsv_to_rgb(in_data));
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (hsv_backlog.size() > 0) begin
        in_data <= hsv_backlog.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 47);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 2);
            2: gap_left = $urandom_range(1, 8);
            default: gap_left = $urandom_range(10, 30);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall in modes that each last a random stretch.
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_hold = $urandom_range(10, 80);
    end
    stall_hold = stall_hold - 1;
    alt_phase = ~alt_phase;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
      default:     out_stall <= alt_phase;
    endcase
  end

  // Compare each delivered colour with the oldest outstanding prediction.
  always @(posedge clk) begin
    hsvrgb_pkg::rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_awaited.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t: unexpected colour expected none, got r=%0d g=%0d b=%0d", $time,
                 out_data.red, out_data.green, out_data.blue);
      end else begin
        want = rgb_awaited.pop_front();
        if (out_data.red !== want.red || out_data.green !== want.green ||
            out_data.blue !== want.blue) begin
          mismatches = mismatches + 1;
          $display("%0t: colour mismatch expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   $time, want.red, want.green, want.blue,
                   out_data.red, out_data.green, out_data.blue);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int kind;
    int h;
    int s;
    int v;

    // directed: hue at sector edges and beyond the circle, clamping of s and v
    queue_colour(0, 10000, 10000);
    queue_colour(5999, 10000, 10000);
    queue_colour(6000, 10000, 10000);
    queue_colour(11999, 10000, 10000);
    queue_colour(12000, 10000, 10000);
    queue_colour(18000, 10000, 10000);
    queue_colour(24000, 10000, 10000);
    queue_colour(30000, 10000, 10000);
    queue_colour(35999, 10000, 10000);
    queue_colour(36000, 10000, 10000);
    queue_colour(41999, 8000, 9000);
    queue_colour(42000, 8000, 9000);
    queue_colour(48000, 5000, 10000);
    queue_colour(60000, 10000, 7000);
    queue_colour(65535, 16383, 16383);
    queue_colour(3000, 0, 10000);
    queue_colour(3000, 10000, 0);
    queue_colour(0, 0, 0);
    queue_colour(20000, 10001, 10001);
    queue_colour(9000, 16383, 5000);
    queue_colour(27000, 5000, 16383);
    queue_colour(1, 1, 1);
    queue_colour(15000, 5000, 5000);
    queue_colour(33333, 9999, 10000);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        h = $urandom_range(0, 35999);
        s = $urandom_range(0, 10000);
        v = $urandom_range(0, 10000);
      end else if (kind == 6) begin
        case ($urandom_range(0, 3))
          0: h = $urandom_range(0, 10) * 6000;
          1: h = $urandom_range(0, 10) * 6000 + 1;
          2: h = $urandom_range(0, 10) * 6000 + 5998;
          default: h = $urandom_range(0, 10) * 6000 + 5999;
        endcase
        if (h > 65535)
          h = 65535;
        s = ($urandom_range(0, 1) == 0) ? 10000 : $urandom_range(0, 10000);
        v = ($urandom_range(0, 1) == 0) ? 10000 : $urandom_range(0, 10000);
      end else if (kind == 7) begin
        h = $urandom_range(36000, 65535);
        s = $urandom_range(0, 16383);
        v = $urandom_range(0, 16383);
      end else begin
        h = $urandom_range(0, 65535);
        s = $urandom_range(0, 16383);
        v = $urandom_range(0, 16383);
      end
      queue_colour(h, s, v);
    end

    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;

    while (hsv_backlog.size() > 0 || in_valid)
      @(posedge clk);
    while (rgb_awaited.size() > 0)
      @(posedge clk);
    // drain: catch any stray result behind the last one
    repeat (4 * PIPE_DEPTH) @(posedge clk);

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/hsvrgb_pkg.sv
src/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_test.sv
